### hdl/vlr_pkg.sv
// ----------------------------------------------------------------------------
// vlr_pkg: shared types and constants for the Voronoi label and relax block
// Request kinds, default sizes and the widths of the per-site accumulators.
// ----------------------------------------------------------------------------
package vlr_pkg;

   localparam int NumSitesDefault  = 128;
   localparam int CoordBitsDefault = 12;
   localparam int IndexBits        = 7;
   localparam int ColorBits        = 24;
   localparam int SumBits          = 36;
   localparam int CountBits        = 24;
   localparam int DispBits         = 20;

   // Request kinds carried in req_tuser.
   typedef enum logic [1:0] {
      REQ_LOAD     = 2'd0,
      REQ_CLASSIFY = 2'd1,
      REQ_RELAX    = 2'd2,
      REQ_NONE     = 2'd3
   } req_kind_type;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_ACCUM = 5'b00100,
      ST_RELAX = 5'b01000,
      ST_SEND  = 5'b10000
   } state_type;

endpackage

### hdl/voronoi_label_and_relax.sv
// ----------------------------------------------------------------------------
// voronoi_label_and_relax: nearest-site labeling with Lloyd relaxation
// Site table held in a chain of cells; accumulators in RAM.
// ----------------------------------------------------------------------------
// Usage: each req transfer carries a request kind in req_tuser and its fields
// in req_tdata; every request yields exactly one rsp transfer.
// A load writes one site and then answers.
// A classify pushes the pixel through the chain of NUM_SITES cells, one cell
// per cycle, then updates the winner's accumulators unless the pixel lies
// exactly on a site or the winner's count is full.
// A relax visits each site in turn and divides both sums by the count with a
// one-bit-per-cycle divider; sites with no pixels are skipped.
// Reset clears the control logic and then sweeps the accumulator RAMs to
// zero, one entry per cycle, while req_tready stays low.
// Site positions are undefined until loaded.
// One request is in progress at a time; while rsp_tready is low the result
// is held and no new request is taken.
// ----------------------------------------------------------------------------
module voronoi_label_and_relax
   import vlr_pkg::*;
#(
   parameter int NUM_SITES  = NumSitesDefault,
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: site_index[6:0], site_x, site_y, site_color, pixel_x, pixel_y, zero pad
   input  logic [79:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: nearest_site[6:0], pixel_color[30:7], displacement[50:31], zero pad
   output logic [55:0] rsp_tdata,
   // tuser: on_site
   output logic        rsp_tuser
);

   localparam int AddrBits = $clog2(NUM_SITES);
   localparam int CntBits  = $clog2(NUM_SITES + 1);
   localparam int DistBits = 2*COORD_BITS + 1;

   // Input fields.
   req_kind_type          kind;
   logic [IndexBits-1:0]  f_index;
   logic [COORD_BITS-1:0] f_sx, f_sy, f_px, f_py;
   logic [ColorBits-1:0]  f_color;

   assign kind    = req_kind_type'(req_tuser);
   assign f_index = req_tdata[6:0];
   assign f_sx    = COORD_BITS'(req_tdata[18:7]);
   assign f_sy    = COORD_BITS'(req_tdata[30:19]);
   assign f_color = req_tdata[31 +: ColorBits];
   assign f_px    = COORD_BITS'(req_tdata[66:55]);
   assign f_py    = COORD_BITS'(req_tdata[78:67]);

   state_type            state_ff, state_in;
   logic                 clear_ff, clear_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   logic [1:0]           phase_ff, phase_in;
   logic [IndexBits-1:0] o_site_ff, o_site_in;
   logic [ColorBits-1:0] o_color_ff, o_color_in;
   logic                 o_on_ff, o_on_in;
   logic [DispBits-1:0]  disp_ff, disp_in;
   logic [COORD_BITS-1:0] nx_ff, nx_in;
   logic [AddrBits-1:0]  win_ff, win_in;
   logic [COORD_BITS-1:0] acc_px_ff, acc_px_in;
   logic [COORD_BITS-1:0] acc_py_ff, acc_py_in;
   logic                 accept;

   // Chain wiring.
   logic [COORD_BITS-1:0] c_px [NUM_SITES+1];
   logic [COORD_BITS-1:0] c_py [NUM_SITES+1];
   logic                  c_hit [NUM_SITES+1];
   logic [IndexBits-1:0]  c_best [NUM_SITES+1];
   logic [DistBits-1:0]   c_dist [NUM_SITES+1];
   logic [ColorBits-1:0]  c_color [NUM_SITES+1];
   logic [COORD_BITS-1:0] s_col [NUM_SITES];
   logic [COORD_BITS-1:0] s_row [NUM_SITES];
   logic [NUM_SITES-1:0]  load_en, move_en;

   assign c_px[0]    = f_px;
   assign c_py[0]    = f_py;
   assign c_hit[0]   = 1'b0;
   assign c_best[0]  = '0;
   assign c_dist[0]  = '0;
   assign c_color[0] = '0;

   // Accumulator RAMs.
   logic                  ram_we;
   logic [AddrBits-1:0]   ram_addr;
   logic [SumBits-1:0]    csum_wr, rsum_wr, csum_rd, rsum_rd;
   logic [CountBits-1:0]  pcnt_wr, pcnt_rd;

   vlr_ram #(.Width(SumBits), .Depth(NUM_SITES)) u_col_sum (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(csum_wr),
      .rd_data(csum_rd));
   vlr_ram #(.Width(SumBits), .Depth(NUM_SITES)) u_row_sum (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(rsum_wr),
      .rd_data(rsum_rd));
   vlr_ram #(.Width(CountBits), .Depth(NUM_SITES)) u_count (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(pcnt_wr),
      .rd_data(pcnt_rd));

   // Shared divider for the centroid.
   logic                 div_start, div_done;
   logic [SumBits-1:0]   div_dividend, div_q;

   vlr_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(pcnt_rd), .done(div_done), .quotient(div_q));

   // Site position of the entry being relaxed.
   logic [COORD_BITS-1:0] cur_col, cur_row;
   assign cur_col = s_col[cnt_ff[AddrBits-1:0]];
   assign cur_row = s_row[cnt_ff[AddrBits-1:0]];

   logic [COORD_BITS-1:0] ny, adx, ady;
   logic [COORD_BITS:0]   mv;
   logic [DispBits:0]     dsum;
   assign ny   = div_q[COORD_BITS-1:0];
   assign adx  = (nx_ff > cur_col) ? nx_ff - cur_col : cur_col - nx_ff;
   assign ady  = (ny > cur_row) ? ny - cur_row : cur_row - ny;
   assign mv   = {1'b0, adx} + {1'b0, ady};
   assign dsum = {1'b0, disp_ff} + (DispBits+1)'(mv);

   genvar gi;
   generate
      for (gi = 0; gi < NUM_SITES; gi++) begin : g_cell
         assign load_en[gi] = accept && kind == REQ_LOAD
                              && {1'b0, f_index} == (IndexBits+1)'(gi);
         assign move_en[gi] = state_ff == ST_RELAX && phase_ff == 2'd3 && div_done
                              && cnt_ff == CntBits'(gi);
         vlr_cell #(.CoordBits(COORD_BITS), .IdxBits(IndexBits), .MyIndex(gi)) u_cell (
            .clock(clock), .load_en(load_en[gi]), .load_col(f_sx), .load_row(f_sy),
            .load_color(f_color), .move_en(move_en[gi]), .move_col(nx_ff),
            .move_row(ny), .site_col(s_col[gi]), .site_row(s_row[gi]),
            .px_in(c_px[gi]), .py_in(c_py[gi]), .hit_in(c_hit[gi]),
            .best_in(c_best[gi]), .dist_in(c_dist[gi]), .color_in(c_color[gi]),
            .px_out(c_px[gi+1]), .py_out(c_py[gi+1]), .hit_out(c_hit[gi+1]),
            .best_out(c_best[gi+1]), .dist_out(c_dist[gi+1]),
            .color_out(c_color[gi+1]));
      end
   endgenerate

   assign req_tready = state_ff == ST_IDLE && !clear_ff;
   assign accept     = req_tvalid && req_tready;

   // Sequencer: clearing sweep, chain scan, accumulate, relax, send.
   always_comb begin
      state_in     = state_ff;
      clear_in     = clear_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      o_site_in    = o_site_ff;
      o_color_in   = o_color_ff;
      o_on_in      = o_on_ff;
      disp_in      = disp_ff;
      nx_in        = nx_ff;
      win_in       = win_ff;
      acc_px_in    = acc_px_ff;
      acc_py_in    = acc_py_ff;
      ram_we       = 1'b0;
      ram_addr     = cnt_ff[AddrBits-1:0];
      csum_wr      = '0;
      rsum_wr      = '0;
      pcnt_wr      = '0;
      div_start    = 1'b0;
      div_dividend = csum_rd;
      unique case (state_ff)
         ST_IDLE: begin
            if (clear_ff) begin
               ram_we = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CntBits'(NUM_SITES - 1)) begin
                  clear_in = 1'b0;
               end
            end else if (accept) begin
               o_site_in  = '0;
               o_color_in = '0;
               o_on_in    = 1'b0;
               disp_in    = '0;
               cnt_in     = '0;
               phase_in   = '0;
               priority case (1'b1)
                  kind == REQ_CLASSIFY: state_in = ST_SCAN;
                  kind == REQ_RELAX:    state_in = ST_RELAX;
                  default:              state_in = ST_SEND;
               endcase
            end
         end
         ST_SCAN: begin
            // The pixel entered cell 0 at accept; it leaves the chain when the scan
            // count reaches its last value. The chain keeps shifting, so the pixel is kept.
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntBits'(NUM_SITES - 1)) begin
               o_site_in  = c_best[NUM_SITES];
               o_on_in    = c_hit[NUM_SITES];
               o_color_in = c_color[NUM_SITES];
               win_in     = AddrBits'(c_best[NUM_SITES]);
               acc_px_in  = c_px[NUM_SITES];
               acc_py_in  = c_py[NUM_SITES];
               phase_in   = '0;
               state_in   = c_hit[NUM_SITES] ? ST_SEND : ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            ram_addr = win_ff;
            phase_in = phase_ff + 1'b1;
            if (phase_ff == 2'd2) begin
               if (pcnt_rd != {CountBits{1'b1}}) begin
                  ram_we  = 1'b1;
                  csum_wr = csum_rd + SumBits'(acc_px_ff);
                  rsum_wr = rsum_rd + SumBits'(acc_py_ff);
                  pcnt_wr = pcnt_rd + 1'b1;
               end
               state_in = ST_SEND;
            end
         end
         ST_RELAX: begin
            unique case (phase_ff)
               2'd0: begin
                  phase_in = 2'd1;
               end
               2'd1: begin
                  if (pcnt_rd == '0) begin
                     phase_in = 2'd0;
                     cnt_in   = cnt_ff + 1'b1;
                     if (cnt_ff == CntBits'(NUM_SITES - 1)) begin
                        state_in = ST_SEND;
                     end
                  end else begin
                     div_start = 1'b1;
                     phase_in  = 2'd2;
                  end
               end
               2'd2: begin
                  if (div_done) begin
                     nx_in        = div_q[COORD_BITS-1:0];
                     div_start    = 1'b1;
                     div_dividend = rsum_rd;
                     phase_in     = 2'd3;
                  end
               end
               default: begin
                  if (div_done) begin
                     disp_in  = dsum[DispBits] ? {DispBits{1'b1}} : dsum[DispBits-1:0];
                     ram_we   = 1'b1;
                     phase_in = 2'd0;
                     cnt_in   = cnt_ff + 1'b1;
                     if (cnt_ff == CntBits'(NUM_SITES - 1)) begin
                        state_in = ST_SEND;
                     end
                  end
               end
            endcase
         end
         ST_SEND: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         clear_ff <= 1'b1;
         cnt_ff   <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
      o_site_ff  <= o_site_in;
      o_color_ff <= o_color_in;
      o_on_ff    <= o_on_in;
      disp_ff    <= disp_in;
      nx_ff      <= nx_in;
      win_ff     <= win_in;
      acc_px_ff  <= acc_px_in;
      acc_py_ff  <= acc_py_in;
   end

   // Result transfer.
   assign rsp_tvalid = state_ff == ST_SEND;
   assign rsp_tdata  = {5'd0, disp_ff, o_color_ff, o_site_ff};
   assign rsp_tuser  = o_on_ff;

endmodule

### hdl/vlr_ram.sv
// ----------------------------------------------------------------------------
// vlr_ram: generic single-port RAM with registered read
// One write and one read per cycle at one address.
// ----------------------------------------------------------------------------
module vlr_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   // Write-first is not needed; plain read-before-write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;

endmodule

### hdl/vlr_divider.sv
// ----------------------------------------------------------------------------
// vlr_divider: restoring divider, one quotient bit per cycle
// Divides a sum by a pixel count; start pulses load the operands.
// ----------------------------------------------------------------------------
module vlr_divider
   import vlr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SumBits-1:0]   dividend,
   input  logic [CountBits-1:0] divisor,
   output logic                 done,
   output logic [SumBits-1:0]   quotient
);

   localparam int StepBits = $clog2(SumBits + 1);

   logic [SumBits-1:0]   quo_ff, quo_in;
   logic [CountBits:0]   rem_ff, rem_in;
   logic [CountBits-1:0] div_ff, div_in;
   logic [StepBits-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CountBits:0]   trial;

   // One shift-subtract step per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[CountBits-1:0], quo_ff[SumBits-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = StepBits'(SumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[SumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == StepBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/vlr_cell.sv
// ----------------------------------------------------------------------------
// vlr_cell: one stage of the nearest-site comparison chain
// Holds one site's position and color and passes the running best onward.
// ----------------------------------------------------------------------------
module vlr_cell
   import vlr_pkg::*;
#(
   parameter int CoordBits = CoordBitsDefault,
   parameter int IdxBits   = IndexBits,
   parameter int MyIndex   = 0
) (
   input  logic                   clock,
   input  logic                   load_en,
   input  logic [CoordBits-1:0]   load_col,
   input  logic [CoordBits-1:0]   load_row,
   input  logic [ColorBits-1:0]   load_color,
   input  logic                   move_en,
   input  logic [CoordBits-1:0]   move_col,
   input  logic [CoordBits-1:0]   move_row,
   output logic [CoordBits-1:0]   site_col,
   output logic [CoordBits-1:0]   site_row,
   input  logic [CoordBits-1:0]   px_in,
   input  logic [CoordBits-1:0]   py_in,
   input  logic                   hit_in,
   input  logic [IdxBits-1:0]     best_in,
   input  logic [2*CoordBits:0]   dist_in,
   input  logic [ColorBits-1:0]   color_in,
   output logic [CoordBits-1:0]   px_out,
   output logic [CoordBits-1:0]   py_out,
   output logic                   hit_out,
   output logic [IdxBits-1:0]     best_out,
   output logic [2*CoordBits:0]   dist_out,
   output logic [ColorBits-1:0]   color_out
);

   logic [CoordBits-1:0] col_ff, row_ff;
   logic [ColorBits-1:0] color_ff;
   logic [CoordBits-1:0] dx, dy;
   logic [2*CoordBits:0] dist_sq;
   logic [CoordBits-1:0] px_ff, py_ff;
   logic                 hit_ff;
   logic [IdxBits-1:0]   best_ff;
   logic [2*CoordBits:0] dist_ff;
   logic [ColorBits-1:0] bcolor_ff;

   // Site storage, written by loads and relax moves.
   always_ff @(posedge clock) begin
      if (load_en) begin
         col_ff   <= load_col;
         row_ff   <= load_row;
         color_ff <= load_color;
      end else if (move_en) begin
         col_ff <= move_col;
         row_ff <= move_row;
      end
   end

   // Squared distance to the incoming pixel.
   always_comb begin
      dx      = (px_in > col_ff) ? px_in - col_ff : col_ff - px_in;
      dy      = (py_in > row_ff) ? py_in - row_ff : row_ff - py_in;
      dist_sq = (2*CoordBits+1)'(dx * dx) + (2*CoordBits+1)'(dy * dy);
   end

   // Pass the best so far; an earlier exact hit freezes it, ties go higher.
   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      if (hit_in) begin
         hit_ff    <= 1'b1;
         best_ff   <= best_in;
         dist_ff   <= dist_in;
         bcolor_ff <= color_in;
      end else if (px_in == col_ff && py_in == row_ff) begin
         hit_ff    <= 1'b1;
         best_ff   <= IdxBits'(MyIndex);
         dist_ff   <= '0;
         bcolor_ff <= '0;
      end else if (MyIndex == 0 || dist_sq <= dist_in) begin
         hit_ff    <= 1'b0;
         best_ff   <= IdxBits'(MyIndex);
         dist_ff   <= dist_sq;
         bcolor_ff <= color_ff;
      end else begin
         hit_ff    <= 1'b0;
         best_ff   <= best_in;
         dist_ff   <= dist_in;
         bcolor_ff <= color_in;
      end
   end

   assign site_col  = col_ff;
   assign site_row  = row_ff;
   assign px_out    = px_ff;
   assign py_out    = py_ff;
   assign hit_out   = hit_ff;
   assign best_out  = best_ff;
   assign dist_out  = dist_ff;
   assign color_out = bcolor_ff;

endmodule
